[rtl/gdci_pkg.sv]
// Package for the gated dual-channel integrator.
// Holds the queue sizing, the command and result codes and the controller state type.
// No dependencies; imported by the integrator core and its port checker.
package gdci_pkg;

    // Window queue sizing.
    localparam int WINDOW_DEPTH = 64;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);

    // At most this many windows close on one input.
    localparam int RESULT_LIMIT = 64;
    localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

    // One queue entry holds the window start above the window end.
    localparam int ENTRY_W = 128;

    // Input commands.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_LOADED   = 3'd0,
        KIND_SKIPPED  = 3'd1,
        KIND_OVERLAP  = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_CLOSED   = 3'd4,
        KIND_MISMATCH = 3'd5
    } kind_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_WAIT
    } state_t;

endpackage

[rtl/gdci_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the gate window queue of the integrator.
module gdci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/gated_dual_channel_integrator.sv]
// Gated dual-channel boxcar integrator: window queue, accumulators and result path.
// Depends on gdci_pkg and gdci_ram.
//
// Usage: the input channel (in_valid / in_stall) carries one command per transfer:
// load a gate window, present a timestamped sample pair, or flush the queue. The
// output channel (out_valid / out_stall) carries result rows; last marks the
// final row that one input causes. A sample pair or flush may cause no row.
// Windows are held in a 64-entry RAM queue read at the head slot; the RAM read
// latency sets the pace of the controller.
// Sequence: an item is captured in idle, decided in the work state, then
// back to idle; each window it closes adds a wait state (RAM read of the new
// head) and a work state (evaluation). A load or mismatch row goes from the
// work state into the output register. Closed-window rows are held in a
// one-row pending stage until the next head is known, so each row is released
// when the following one is decided, and the final one when the run ends.
// A stalled receiver holds the output register; the controller waits while the
// output and pending rows are full, and does not take new input until done.
// Reset empties the queue and clears all counters and accumulators at once; no
// clearing pass over the RAM is needed because occupancy guards every read.
module gated_dual_channel_integrator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] window_start,
    input  logic [63:0] window_end,
    input  logic [63:0] sample_time,
    input  logic [63:0] other_time,
    input  logic signed [31:0] level_a,
    input  logic signed [31:0] level_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] window_number,
    output logic signed [63:0] total_a,
    output logic signed [63:0] total_b,
    output logic [31:0] sample_count,
    output logic        last
);
    import gdci_pkg::*;

    localparam logic [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    // Saturating add of a signed 32-bit sample to a signed 64-bit sum.
    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [31:0] x);
        logic [63:0] ext;
        logic [63:0] sum;
        ext = {{32{x[31]}}, x};
        sum = acc + ext;
        if (acc[63] == ext[63] && sum[63] != acc[63])
        begin
            return acc[63] ? ACC_MIN : ACC_MAX;
        end
        return sum;
    endfunction

    // Circular slot increment for any queue depth.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(WINDOW_DEPTH - 1))
        begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    state_t state_reg, state_next;

    // Captured item.
    op_t         op_reg;
    logic [63:0] ws_reg;
    logic [63:0] we_reg;
    logic [63:0] ts_reg;
    logic        mismatch_reg;
    logic [31:0] la_reg;
    logic [31:0] lb_reg;

    // Queue and integrator state.
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] tail_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [63:0]       prev_end_reg;
    logic [63:0]       acc_a_reg;
    logic [63:0]       acc_b_reg;
    logic [31:0]       acc_n_reg;
    logic [31:0]       closed_reg;
    logic [31:0]       loaded_reg;
    logic [EMIT_W-1:0] emit_reg;

    // Pending closed-window row.
    logic        pend_valid_reg;
    logic [31:0] pend_number_reg;
    logic [63:0] pend_a_reg;
    logic [63:0] pend_b_reg;
    logic [31:0] pend_n_reg;

    // Output register.
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_number_reg;
    logic [63:0] out_a_reg;
    logic [63:0] out_b_reg;
    logic [31:0] out_count_reg;
    logic        out_last_reg;

    // Queue RAM.
    logic [ENTRY_W-1:0] rd_data;
    logic [63:0]        head_start;
    logic [63:0]        head_end;

    // Work decisions.
    logic        accept;
    logic        out_free;
    logic        occ_nz;
    logic        want_close;
    logic        close_go;
    logic        finish;
    logic        push;
    logic        push_pend;
    logic        push_last;
    logic        load_go;
    logic        integrate;
    kind_t       row_kind;
    kind_t       load_kind;
    logic [31:0] row_number;

    gdci_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (load_go),
        .wr_addr (tail_reg),
        .wr_data ({ws_reg, we_reg}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign head_start = rd_data[ENTRY_W-1:64];
    assign head_end   = rd_data[63:0];
    assign occ_nz     = (occ_reg != '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign accept     = in_valid && !in_stall;

    // Load checks, in priority order.
    always_comb
    begin
        if (we_reg <= ws_reg)
            load_kind = KIND_SKIPPED;
        else if (ws_reg < prev_end_reg)
            load_kind = KIND_OVERLAP;
        else if (occ_reg >= OCC_W'(WINDOW_DEPTH))
            load_kind = KIND_FULL;
        else
            load_kind = KIND_LOADED;
    end

    // A head window closes when expired (or on flush) and the per-input limit allows.
    always_comb
    begin
        want_close = occ_nz && (emit_reg < EMIT_W'(RESULT_LIMIT)) &&
                     ((op_reg == OP_FLUSH) ||
                      (op_reg == OP_SAMPLE && !mismatch_reg && ts_reg >= head_end));
    end

    // Per-cycle decisions of the work state.
    always_comb
    begin
        close_go   = 1'b0;
        finish     = 1'b0;
        push       = 1'b0;
        push_pend  = 1'b0;
        push_last  = 1'b0;
        load_go    = 1'b0;
        integrate  = 1'b0;
        row_kind   = KIND_MISMATCH;
        row_number = '0;
        if (state_reg == S_WORK)
        begin
            case (op_reg)
                OP_LOAD:
                begin
                    if (out_free)
                    begin
                        finish    = 1'b1;
                        push      = 1'b1;
                        push_last = 1'b1;
                        row_kind  = load_kind;
                        load_go   = (load_kind == KIND_LOADED);
                        row_number = load_go ? loaded_reg : '0;
                    end
                end
                OP_SAMPLE, OP_FLUSH:
                begin
                    if (op_reg == OP_SAMPLE && mismatch_reg)
                    begin
                        if (out_free)
                        begin
                            finish    = 1'b1;
                            push      = 1'b1;
                            push_last = 1'b1;
                            row_kind  = KIND_MISMATCH;
                        end
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        push      = pend_valid_reg;
                        push_pend = 1'b1;
                        if (want_close)
                        begin
                            close_go = 1'b1;
                        end
                        else
                        begin
                            finish    = 1'b1;
                            push_last = 1'b1;
                            integrate = (op_reg == OP_SAMPLE) && occ_nz &&
                                        (ts_reg < head_end) && (ts_reg >= head_start);
                        end
                    end
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_WORK;
            end
            S_WORK:
            begin
                if (close_go)
                    state_next = S_WAIT;
                else if (finish)
                    state_next = S_IDLE;
            end
            S_WAIT:
            begin
                state_next = S_WORK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State-machine outputs.
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Item capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(op);
            ws_reg       <= window_start;
            we_reg       <= window_end;
            ts_reg       <= sample_time;
            mismatch_reg <= (sample_time != other_time);
            la_reg       <= level_a;
            lb_reg       <= level_b;
        end
    end

    // Queue pointers, accumulators and running counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            prev_end_reg <= '0;
            acc_a_reg    <= '0;
            acc_b_reg    <= '0;
            acc_n_reg    <= '0;
            closed_reg   <= '0;
            loaded_reg   <= '0;
            emit_reg     <= '0;
        end
        else
        begin
            if (accept)
                emit_reg <= '0;
            if (load_go)
            begin
                tail_reg     <= next_slot(tail_reg);
                occ_reg      <= occ_reg + 1'b1;
                prev_end_reg <= we_reg;
                loaded_reg   <= loaded_reg + 1'b1;
            end
            if (close_go)
            begin
                head_reg   <= next_slot(head_reg);
                occ_reg    <= occ_reg - 1'b1;
                acc_a_reg  <= '0;
                acc_b_reg  <= '0;
                acc_n_reg  <= '0;
                closed_reg <= closed_reg + 1'b1;
                emit_reg   <= emit_reg + 1'b1;
            end
            if (integrate)
            begin
                acc_a_reg <= sat_add(acc_a_reg, la_reg);
                acc_b_reg <= sat_add(acc_b_reg, lb_reg);
                if (acc_n_reg != '1)
                    acc_n_reg <= acc_n_reg + 1'b1;
            end
        end
    end

    // Pending closed-window row; released once the next decision is known.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (close_go)
            pend_valid_reg <= 1'b1;
        else if (finish && push_pend)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (close_go)
        begin
            pend_number_reg <= closed_reg;
            pend_a_reg      <= acc_a_reg;
            pend_b_reg      <= acc_b_reg;
            pend_n_reg      <= acc_n_reg;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_last_reg <= push_last;
            if (push_pend)
            begin
                out_kind_reg   <= KIND_CLOSED;
                out_number_reg <= pend_number_reg;
                out_a_reg      <= pend_a_reg;
                out_b_reg      <= pend_b_reg;
                out_count_reg  <= pend_n_reg;
            end
            else
            begin
                out_kind_reg   <= row_kind;
                out_number_reg <= row_number;
                out_a_reg      <= '0;
                out_b_reg      <= '0;
                out_count_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign window_number = out_number_reg;
    assign total_a       = $signed(out_a_reg);
    assign total_b       = $signed(out_b_reg);
    assign sample_count  = out_count_reg;
    assign last          = out_last_reg;

endmodule

[rtl/gdci_checker.sv]
// Port-level checker for the gated dual-channel integrator, with its bind.
// Depends on gdci_pkg; attaches to gated_dual_channel_integrator.
module gdci_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [31:0] window_number,
    input logic signed [63:0] total_a,
    input logic signed [63:0] total_b,
    input logic [31:0] sample_count,
    input logic        last
);
    import gdci_pkg::*;

    logic row_is_status;
    logic row_is_refusal;

    // Rows that are not closed windows carry no sums.
    assign row_is_status = (kind == KIND_LOADED) || (kind == KIND_SKIPPED) ||
                           (kind == KIND_OVERLAP) || (kind == KIND_FULL) ||
                           (kind == KIND_MISMATCH);
    assign row_is_refusal = (kind == KIND_SKIPPED) || (kind == KIND_OVERLAP) ||
                            (kind == KIND_FULL) || (kind == KIND_MISMATCH);

    // A stalled result transfer holds its row.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last) &&
        $stable(window_number) && $stable(total_a) && $stable(sample_count))
        else $error("stalled result changed");

    // Load and mismatch rows carry zero sums and counts.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_is_status |-> total_a == 0 && total_b == 0 && sample_count == 0)
        else $error("status row carries nonzero sums");

    // Load and mismatch rows are always the only row of their input.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_is_status |-> last)
        else $error("status row without last");

    // Refused loads and mismatches carry no window number.
    a_refusal_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_is_refusal |-> window_number == 0)
        else $error("refusal row with window number");

endmodule

bind gated_dual_channel_integrator gdci_checker u_gdci_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .window_number (window_number),
    .total_a       (total_a),
    .total_b       (total_b),
    .sample_count  (sample_count),
    .last          (last)
);
